>>> hdl/chuf_pkg.sv
// Shared types, constants and sizes for the canonical Huffman encoder.
package chuf_pkg;

    localparam int NUM_SYMBOLS  = 256;
    localparam int SYM_W        = $clog2(NUM_SYMBOLS);
    localparam int MAX_CODE_LEN = 16;
    localparam int LEN_W        = 5;
    localparam int CODE_W       = 16;
    localparam int CNT_W        = SYM_W + 1;
    localparam int ACC_W        = MAX_CODE_LEN + 1;
    localparam int SUM_W        = SYM_W + MAX_CODE_LEN;

    localparam logic [SUM_W-1:0] KRAFT_LIMIT = SUM_W'(1) << MAX_CODE_LEN;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_BUILD  = 2'd1,
        ACT_ENCODE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_KRAFT     = 2'd1,
        ST_NOT_BUILT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENC,
        S_KRAFT,
        S_FIRST,
        S_ASSIGN,
        S_RESP
    } state_t;

    typedef struct packed {
        action_t            action;
        logic [SYM_W-1:0]   symbol;
        logic [LEN_W-1:0]   length;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0]  code_word;
        logic [LEN_W-1:0]   code_length;
        status_t            status;
    } out_item_t;

    typedef struct packed {
        logic               wr;
        logic [SYM_W-1:0]   waddr;
        logic [LEN_W-1:0]   wdata;
        logic [SYM_W-1:0]   raddr;
    } len_req_t;

    typedef struct packed {
        logic               wr;
        logic [SYM_W-1:0]   waddr;
        logic [CODE_W-1:0]  wdata;
        logic [SYM_W-1:0]   raddr;
    } code_req_t;

endpackage

>>> hdl/chuf_len_store.sv
// Code length memory with per-entry valid bits; unwritten entries read as zero.
module chuf_len_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  chuf_pkg::len_req_t          req,
    output logic [chuf_pkg::LEN_W-1:0]  length
);

    logic [chuf_pkg::LEN_W-1:0]       mem [chuf_pkg::NUM_SYMBOLS];
    logic [chuf_pkg::NUM_SYMBOLS-1:0] vld_reg;
    logic [chuf_pkg::LEN_W-1:0]       q_reg;
    logic                             q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.waddr] <= req.wdata;
        end
        q_reg <= mem[req.raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr)
            begin
                vld_reg[req.waddr] <= 1'b1;
            end
            q_vld_reg <= vld_reg[req.raddr];
        end
    end

    assign length = q_vld_reg ? q_reg : '0;

endmodule

>>> hdl/chuf_code_store.sv
// Code word memory, one write and one registered read per cycle.
module chuf_code_store (
    input  logic                         clk,
    input  chuf_pkg::code_req_t          req,
    output logic [chuf_pkg::CODE_W-1:0]  code_word
);

    logic [chuf_pkg::CODE_W-1:0] mem [chuf_pkg::NUM_SYMBOLS];
    logic [chuf_pkg::CODE_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.waddr] <= req.wdata;
        end
        q_reg <= mem[req.raddr];
    end

    assign code_word = q_reg;

endmodule

>>> hdl/chuf_ctrl.sv
// Sequencer: item decode, Kraft check pass, first-code steps and code assignment pass.
module chuf_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sym_valid,
    output logic                         sym_stall,
    input  chuf_pkg::in_item_t           sym_item,
    input  logic                         out_free,
    output logic                         done,
    output chuf_pkg::out_item_t          res,
    output chuf_pkg::len_req_t           len_req,
    input  logic [chuf_pkg::LEN_W-1:0]   len_q,
    output chuf_pkg::code_req_t          code_req,
    input  logic [chuf_pkg::CODE_W-1:0]  code_q
);

    chuf_pkg::state_t                  state_reg, state_next;
    logic [chuf_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                              rd_pend_reg, rd_pend_next;
    logic [chuf_pkg::SYM_W-1:0]        addr_q_reg, addr_q_next;
    logic [chuf_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic                              bad_reg, bad_next;
    logic                              ready_reg, ready_next;
    logic [chuf_pkg::ACC_W-1:0]        acc_reg, acc_next;
    chuf_pkg::out_item_t               res_reg, res_next;
    logic [chuf_pkg::CNT_W-1:0]        count_reg [chuf_pkg::MAX_CODE_LEN+1];
    logic [chuf_pkg::CNT_W-1:0]        count_next [chuf_pkg::MAX_CODE_LEN+1];
    logic [chuf_pkg::MAX_CODE_LEN-1:0] ncode_reg [chuf_pkg::MAX_CODE_LEN+1];
    logic [chuf_pkg::MAX_CODE_LEN-1:0] ncode_next [chuf_pkg::MAX_CODE_LEN+1];

    logic                              fin;
    chuf_pkg::out_item_t               fin_res;
    logic                              issue;
    logic [chuf_pkg::LEN_W-1:0]        step;
    logic [chuf_pkg::ACC_W-1:0]        step_code;

    assign sym_stall = (state_reg != chuf_pkg::S_IDLE);
    assign issue     = (cnt_reg < chuf_pkg::CNT_W'(chuf_pkg::NUM_SYMBOLS));
    assign step      = cnt_reg[chuf_pkg::LEN_W-1:0];
    // next first code: (code + count of previous length) << 1
    assign step_code = chuf_pkg::ACC_W'((acc_reg
                     + chuf_pkg::ACC_W'(count_reg[chuf_pkg::LEN_W'(step - 1'b1)])) << 1);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rd_pend_next = 1'b0;
        addr_q_next  = addr_q_reg;
        sum_next     = sum_reg;
        bad_next     = bad_reg;
        ready_next   = ready_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        count_next   = count_reg;
        ncode_next   = ncode_reg;

        fin                 = 1'b0;
        fin_res.code_word   = '0;
        fin_res.code_length = '0;
        fin_res.status      = chuf_pkg::ST_OK;
        done                = 1'b0;
        res                 = res_reg;

        len_req.wr    = 1'b0;
        len_req.waddr = sym_item.symbol;
        len_req.wdata = sym_item.length;
        len_req.raddr = (state_reg == chuf_pkg::S_IDLE) ? sym_item.symbol
                                                        : cnt_reg[chuf_pkg::SYM_W-1:0];

        code_req.wr    = 1'b0;
        code_req.waddr = addr_q_reg;
        code_req.wdata = chuf_pkg::CODE_W'(ncode_reg[len_q]);
        code_req.raddr = sym_item.symbol;

        unique case (state_reg)
            chuf_pkg::S_IDLE:
            begin
                if (sym_valid)
                begin
                    unique case (sym_item.action)
                        chuf_pkg::ACT_LOAD:
                        begin
                            len_req.wr = 1'b1;
                            ready_next = 1'b0;
                            fin        = 1'b1;
                        end
                        chuf_pkg::ACT_BUILD:
                        begin
                            cnt_next = '0;
                            sum_next = '0;
                            bad_next = 1'b0;
                            for (int i = 0; i <= chuf_pkg::MAX_CODE_LEN; i++)
                            begin
                                count_next[i] = '0;
                            end
                            state_next = chuf_pkg::S_KRAFT;
                        end
                        chuf_pkg::ACT_ENCODE:
                        begin
                            state_next = chuf_pkg::S_ENC;
                        end
                        chuf_pkg::ACT_NONE:
                        begin
                            fin = 1'b1;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            chuf_pkg::S_ENC:
            begin
                fin = 1'b1;
                if (!ready_reg)
                begin
                    fin_res.status = chuf_pkg::ST_NOT_BUILT;
                end
                else if (len_q != '0)
                begin
                    fin_res.code_word   = code_q;
                    fin_res.code_length = len_q;
                end
            end

            chuf_pkg::S_KRAFT:
            begin
                if (issue)
                begin
                    cnt_next    = cnt_reg + 1'b1;
                    addr_q_next = cnt_reg[chuf_pkg::SYM_W-1:0];
                end
                rd_pend_next = issue;
                if (rd_pend_reg)
                begin
                    if (len_q > chuf_pkg::LEN_W'(chuf_pkg::MAX_CODE_LEN))
                    begin
                        bad_next = 1'b1;
                    end
                    else if (len_q != '0)
                    begin
                        sum_next = sum_reg + (chuf_pkg::SUM_W'(1)
                                 << (chuf_pkg::MAX_CODE_LEN - int'(len_q)));
                        count_next[len_q] = count_reg[len_q] + 1'b1;
                    end
                end
                else if (!issue)
                begin
                    if (bad_reg || sum_reg > chuf_pkg::KRAFT_LIMIT)
                    begin
                        ready_next     = 1'b0;
                        fin            = 1'b1;
                        fin_res.status = chuf_pkg::ST_KRAFT;
                    end
                    else
                    begin
                        cnt_next   = chuf_pkg::CNT_W'(1);
                        acc_next   = '0;
                        state_next = chuf_pkg::S_FIRST;
                    end
                end
            end

            chuf_pkg::S_FIRST:
            begin
                ncode_next[step] = step_code[chuf_pkg::MAX_CODE_LEN-1:0];
                acc_next         = step_code;
                if (step == chuf_pkg::LEN_W'(chuf_pkg::MAX_CODE_LEN))
                begin
                    cnt_next   = '0;
                    state_next = chuf_pkg::S_ASSIGN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            chuf_pkg::S_ASSIGN:
            begin
                if (issue)
                begin
                    cnt_next    = cnt_reg + 1'b1;
                    addr_q_next = cnt_reg[chuf_pkg::SYM_W-1:0];
                end
                rd_pend_next = issue;
                if (rd_pend_reg)
                begin
                    if (len_q != '0)
                    begin
                        code_req.wr       = 1'b1;
                        ncode_next[len_q] = ncode_reg[len_q] + 1'b1;
                    end
                end
                else if (!issue)
                begin
                    ready_next = 1'b1;
                    fin        = 1'b1;
                end
            end

            chuf_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = chuf_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = chuf_pkg::S_IDLE;
            end
        endcase

        // result goes straight out when the output register is free, else it is parked
        if (fin)
        begin
            if (out_free)
            begin
                done       = 1'b1;
                res        = fin_res;
                state_next = chuf_pkg::S_IDLE;
            end
            else
            begin
                res_next   = fin_res;
                state_next = chuf_pkg::S_RESP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= chuf_pkg::S_IDLE;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            ready_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_pend_next;
            ready_reg   <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_q_reg <= addr_q_next;
        sum_reg    <= sum_next;
        bad_reg    <= bad_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        count_reg  <= count_next;
        ncode_reg  <= ncode_next;
    end

endmodule

>>> hdl/canonical_huffman_encoder_top.sv
// Canonical Huffman encoder top level: stores, sequencer and output register.
//
// Load and no-op items finish in the idle state; an encode item goes through
// one more state, for a read of the length and code memories. A build item walks
// the length memory one entry a cycle for a Kraft sum and per-length count
// pass and, if that check passes, takes one step per code length and walks
// it again for the code assignment pass; input is stalled until its result
// is out. A finished result waits in the output register while the next
// item is taken.
module canonical_huffman_encoder_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sym_valid,
    output logic                 sym_stall,
    input  chuf_pkg::in_item_t   sym_item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output chuf_pkg::out_item_t  res_item
);

    chuf_pkg::len_req_t           len_req;
    chuf_pkg::code_req_t          code_req;
    logic [chuf_pkg::LEN_W-1:0]   len_q;
    logic [chuf_pkg::CODE_W-1:0]  code_q;
    logic                         out_free;
    logic                         done;
    chuf_pkg::out_item_t          res;
    logic                         out_valid_reg;
    chuf_pkg::out_item_t          out_item_reg;

    assign out_free  = !out_valid_reg || !res_stall;
    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

    chuf_len_store u_len_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (len_req),
        .length (len_q)
    );

    chuf_code_store u_code_store (
        .clk       (clk),
        .req       (code_req),
        .code_word (code_q)
    );

    chuf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym_item  (sym_item),
        .out_free  (out_free),
        .done      (done),
        .res       (res),
        .len_req   (len_req),
        .len_q     (len_q),
        .code_req  (code_req),
        .code_q    (code_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_item_reg <= res;
        end
    end

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the canonical Huffman encoder: table, code build and encode.
`timescale 1ns / 1ps

module tb_top;

    localparam int              HOLD_CYC   = 300;   // long receiver hold-off
    localparam int              IDLE_LIMIT = 4000;  // build pass plus hold-off, with margin
    localparam int              DRAIN_CYC  = 20;
    localparam int              ITEM_GOAL  = 450;
    localparam longint unsigned KRAFT_FULL = 64'd1 << chuf_pkg::MAX_CODE_LEN;

    localparam chuf_pkg::out_item_t R_OK   = {16'd0, 5'd0, chuf_pkg::ST_OK};
    localparam chuf_pkg::out_item_t R_KRAF = {16'd0, 5'd0, chuf_pkg::ST_KRAFT};
    localparam chuf_pkg::out_item_t R_NB   = {16'd0, 5'd0, chuf_pkg::ST_NOT_BUILT};
    localparam chuf_pkg::out_item_t R_C0L1 = {16'd0, 5'd1, chuf_pkg::ST_OK};
    localparam chuf_pkg::out_item_t R_C1L1 = {16'd1, 5'd1, chuf_pkg::ST_OK};

    typedef struct packed {
        chuf_pkg::action_t            act;
        logic [chuf_pkg::SYM_W-1:0]   sym;
        logic [chuf_pkg::LEN_W-1:0]   len;
        logic                         typed;
        chuf_pkg::out_item_t          res;
    } dir_row_t;

    // rows with typed=0 are checked against the predictor
    localparam dir_row_t DIR_ROWS [25] = '{
        {chuf_pkg::ACT_ENCODE, 8'h00, 5'd0,  1'b1, R_NB},
        {chuf_pkg::ACT_NONE,   8'hAA, 5'd21, 1'b1, R_OK},
        {chuf_pkg::ACT_BUILD,  8'h00, 5'd0,  1'b1, R_OK},
        {chuf_pkg::ACT_ENCODE, 8'hFF, 5'd0,  1'b1, R_OK},
        {chuf_pkg::ACT_LOAD,   8'hFF, 5'd1,  1'b1, R_OK},
        {chuf_pkg::ACT_LOAD,   8'h00, 5'd1,  1'b1, R_OK},
        {chuf_pkg::ACT_ENCODE, 8'h00, 5'd0,  1'b1, R_NB},
        {chuf_pkg::ACT_BUILD,  8'h00, 5'd0,  1'b1, R_OK},
        {chuf_pkg::ACT_ENCODE, 8'h00, 5'd0,  1'b1, R_C0L1},
        {chuf_pkg::ACT_ENCODE, 8'hFF, 5'd0,  1'b1, R_C1L1},
        {chuf_pkg::ACT_LOAD,   8'h07, 5'd31, 1'b1, R_OK},
        {chuf_pkg::ACT_BUILD,  8'h00, 5'd0,  1'b1, R_KRAF},
        {chuf_pkg::ACT_ENCODE, 8'hFF, 5'd0,  1'b1, R_NB},
        {chuf_pkg::ACT_LOAD,   8'h07, 5'd16, 1'b1, R_OK},
        {chuf_pkg::ACT_BUILD,  8'h00, 5'd0,  1'b1, R_KRAF},
        {chuf_pkg::ACT_LOAD,   8'h07, 5'd0,  1'b1, R_OK},
        {chuf_pkg::ACT_LOAD,   8'h00, 5'd16, 1'b1, R_OK},
        {chuf_pkg::ACT_BUILD,  8'h00, 5'd0,  1'b1, R_OK},
        {chuf_pkg::ACT_ENCODE, 8'h00, 5'd0,  1'b0, R_OK},
        {chuf_pkg::ACT_ENCODE, 8'hFF, 5'd0,  1'b0, R_OK},
        {chuf_pkg::ACT_NONE,   8'hFF, 5'd31, 1'b1, R_OK},
        {chuf_pkg::ACT_LOAD,   8'h80, 5'd2,  1'b1, R_OK},
        {chuf_pkg::ACT_BUILD,  8'h00, 5'd0,  1'b0, R_OK},
        {chuf_pkg::ACT_ENCODE, 8'h80, 5'd0,  1'b0, R_OK},
        {chuf_pkg::ACT_ENCODE, 8'h00, 5'd0,  1'b0, R_OK}
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                sym_valid = 1'b0;
    logic                sym_stall;
    chuf_pkg::in_item_t  sym_item  = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    chuf_pkg::out_item_t res_item;

    // predictor state
    logic [chuf_pkg::LEN_W-1:0]  len_mem  [chuf_pkg::NUM_SYMBOLS];
    logic [chuf_pkg::CODE_W-1:0] code_mem [chuf_pkg::NUM_SYMBOLS];
    bit                          codes_built;

    chuf_pkg::out_item_t pending_codes [$];
    int        n_fail      = 0;
    int        n_checked   = 0;
    int        n_items     = 0;
    int        n_build_ok  = 0;
    int        n_build_bad = 0;
    int        n_hits      = 0;
    int        burst_left  = 0;
    int        quiet_items = 0;
    bit        hold_go     = 1'b0;

    canonical_huffman_encoder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym_item  (sym_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #2 clk = ~clk;

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Kraft sum over used symbols, leaving out one; an over-long length counts as overflow
    function automatic longint unsigned kraft_sum(input int skip);
        longint unsigned acc;
        acc = 0;
        for (int s = 0; s < chuf_pkg::NUM_SYMBOLS; s++)
        begin
            if (s != skip && len_mem[s] != 0)
            begin
                if (len_mem[s] > chuf_pkg::MAX_CODE_LEN)
                    return 64'd1 << 40;
                acc += 64'd1 << (chuf_pkg::MAX_CODE_LEN - len_mem[s]);
            end
        end
        return acc;
    endfunction

    function automatic void assign_codes();
        logic [63:0] prev;
        logic [63:0] cw;
        int          prev_len;
        bit          first;
        prev     = '0;
        prev_len = 0;
        first    = 1'b1;
        for (int s = 0; s < chuf_pkg::NUM_SYMBOLS; s++)
            code_mem[s] = '0;
        for (int l = 1; l <= chuf_pkg::MAX_CODE_LEN; l++)
        begin
            for (int s = 0; s < chuf_pkg::NUM_SYMBOLS; s++)
            begin
                if (len_mem[s] == l)
                begin
                    if (first)
                    begin
                        cw    = '0;
                        first = 1'b0;
                    end
                    else
                        cw = (prev + 64'd1) << (l - prev_len);
                    code_mem[s] = cw[chuf_pkg::CODE_W-1:0];
                    prev        = {32'd0, cw[31:0]};
                    prev_len    = l;
                end
            end
        end
    endfunction

    function automatic chuf_pkg::out_item_t next_code_result(input chuf_pkg::in_item_t it);
        chuf_pkg::out_item_t r;
        r        = '0;
        r.status = chuf_pkg::ST_OK;
        case (it.action)
            chuf_pkg::ACT_LOAD:
            begin
                len_mem[it.symbol] = it.length;
                codes_built        = 1'b0;
            end
            chuf_pkg::ACT_BUILD:
            begin
                if (kraft_sum(-1) <= KRAFT_FULL)
                begin
                    assign_codes();
                    codes_built = 1'b1;
                end
                else
                begin
                    codes_built = 1'b0;
                    r.status    = chuf_pkg::ST_KRAFT;
                end
            end
            chuf_pkg::ACT_ENCODE:
            begin
                if (!codes_built)
                    r.status = chuf_pkg::ST_NOT_BUILT;
                else if (len_mem[it.symbol] != 0)
                begin
                    r.code_word   = code_mem[it.symbol];
                    r.code_length = len_mem[it.symbol];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // offers one item in bursts with random gaps, waits for it to be taken, then predicts
    task automatic send_item(input chuf_pkg::action_t act,
                             input logic [chuf_pkg::SYM_W-1:0] sym,
                             input logic [chuf_pkg::LEN_W-1:0] len, input bit typed = 1'b0,
                             input chuf_pkg::out_item_t typed_res = '0);
        chuf_pkg::in_item_t  it;
        chuf_pkg::out_item_t pred;
        int                  gap;
        it.action = act;
        it.symbol = sym;
        it.length = len;
        if (quiet_items > 0)
            quiet_items--;
        else if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                sym_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        sym_valid <= 1'b1;
        sym_item  <= it;
        @(posedge clk);
        while (sym_stall)
            @(posedge clk);
        pred = next_code_result(it);
        pending_codes.push_back(typed ? typed_res : pred);
        if (act != chuf_pkg::ACT_NONE)
            n_items++;
        if (act == chuf_pkg::ACT_BUILD)
        begin
            if (pred.status == chuf_pkg::ST_OK)
                n_build_ok++;
            else
                n_build_bad++;
        end
        if (act == chuf_pkg::ACT_ENCODE && pred.code_length != 0)
            n_hits++;
    endtask

    // drop some used lengths (every over-long one), all of them if the table no longer fits, when asked or at random
    task automatic trim_table(input bit all);
        bit wipe;
        wipe = all || (kraft_sum(-1) > KRAFT_FULL) || ($urandom_range(0, 7) == 0);
        for (int s = 0; s < chuf_pkg::NUM_SYMBOLS; s++)
        begin
            if (len_mem[s] != 0 && (wipe || len_mem[s] > chuf_pkg::MAX_CODE_LEN
                                    || $urandom_range(0, 3) != 0))
                send_item(chuf_pkg::ACT_LOAD, chuf_pkg::SYM_W'(s), '0);
        end
    endtask

    // random lengths, lengthened where needed, or cleared, so that the table still fits
    task automatic fill_lengths(input int n);
        logic [chuf_pkg::SYM_W-1:0] s;
        longint unsigned            base;
        int                         l;
        repeat (n)
        begin
            s    = chuf_pkg::SYM_W'($urandom_range(0, chuf_pkg::NUM_SYMBOLS - 1));
            base = kraft_sum(int'(s));
            l    = $urandom_range(1, $urandom_range(2, chuf_pkg::MAX_CODE_LEN));
            while (l < chuf_pkg::MAX_CODE_LEN
                   && base + (64'd1 << (chuf_pkg::MAX_CODE_LEN - l)) > KRAFT_FULL)
                l++;
            if (base + (64'd1 << (chuf_pkg::MAX_CODE_LEN - l)) > KRAFT_FULL)
                l = 0;
            send_item(chuf_pkg::ACT_LOAD, s, chuf_pkg::LEN_W'(l));
        end
    endtask

    // complete code down to the longest length, so the last code is all ones
    task automatic fill_ladder();
        logic [chuf_pkg::SYM_W-1:0] start;
        logic [chuf_pkg::SYM_W-1:0] stride;
        int                         l;
        trim_table(1'b1);
        start  = chuf_pkg::SYM_W'($urandom_range(0, chuf_pkg::NUM_SYMBOLS - 1));
        stride = chuf_pkg::SYM_W'(2 * $urandom_range(0, chuf_pkg::NUM_SYMBOLS / 2 - 1) + 1);
        for (int i = 0; i <= chuf_pkg::MAX_CODE_LEN; i++)
        begin
            l = (i < chuf_pkg::MAX_CODE_LEN) ? i + 1 : chuf_pkg::MAX_CODE_LEN;
            send_item(chuf_pkg::ACT_LOAD, start + chuf_pkg::SYM_W'(i) * stride,
                      chuf_pkg::LEN_W'(l));
        end
    endtask

    task automatic encode_some(input int n);
        logic [chuf_pkg::SYM_W-1:0] used [$];
        logic [chuf_pkg::SYM_W-1:0] s;
        for (int i = 0; i < chuf_pkg::NUM_SYMBOLS; i++)
            if (len_mem[i] != 0)
                used.push_back(chuf_pkg::SYM_W'(i));
        repeat (n)
        begin
            if (used.size() != 0 && $urandom_range(0, 3) != 0)
                s = used[$urandom_range(0, used.size() - 1)];
            else
                s = chuf_pkg::SYM_W'($urandom_range(0, chuf_pkg::NUM_SYMBOLS - 1));
            send_item(chuf_pkg::ACT_ENCODE, s, chuf_pkg::LEN_W'($urandom_range(0, 31)));
        end
    endtask

    task automatic run_sequence();
        int                         kind;
        logic [chuf_pkg::SYM_W-1:0] s;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            if ($urandom_range(0, 3) == 0)
                fill_ladder();
            else
            begin
                trim_table(1'b0);
                fill_lengths($urandom_range(1, 12));
            end
            send_item(chuf_pkg::ACT_BUILD, chuf_pkg::SYM_W'($urandom_range(0, 255)),
                      chuf_pkg::LEN_W'($urandom_range(0, 31)));
            encode_some($urandom_range(4, 16));
        end
        else if (kind <= 7)
        begin
            // noise: any action, any field value
            repeat ($urandom_range(3, 10))
                send_item(chuf_pkg::action_t'($urandom_range(0, 3)),
                          chuf_pkg::SYM_W'($urandom_range(0, 255)),
                          chuf_pkg::LEN_W'($urandom_range(0, 31)));
        end
        else if (kind == 8)
        begin
            // broken set: over-long length or too many short codes
            trim_table(1'b0);
            fill_lengths($urandom_range(1, 6));
            s = chuf_pkg::SYM_W'($urandom_range(0, chuf_pkg::NUM_SYMBOLS - 1));
            if ($urandom_range(0, 1) == 0)
                send_item(chuf_pkg::ACT_LOAD, s,
                          chuf_pkg::LEN_W'($urandom_range(chuf_pkg::MAX_CODE_LEN + 1, 31)));
            else
            begin
                send_item(chuf_pkg::ACT_LOAD, s, 5'd1);
                send_item(chuf_pkg::ACT_LOAD, s + 8'd1, 5'd1);
                send_item(chuf_pkg::ACT_LOAD, s + 8'd2, 5'd2);
            end
            send_item(chuf_pkg::ACT_BUILD, chuf_pkg::SYM_W'($urandom_range(0, 255)),
                      chuf_pkg::LEN_W'($urandom_range(0, 31)));
            encode_some($urandom_range(2, 6));
        end
        else
        begin
            // stale codes: a load with no rebuild, then encodes
            send_item(chuf_pkg::ACT_LOAD, chuf_pkg::SYM_W'($urandom_range(0, 255)),
                      chuf_pkg::LEN_W'($urandom_range(0, chuf_pkg::MAX_CODE_LEN)));
            if ($urandom_range(0, 1) == 0)
                send_item(chuf_pkg::ACT_NONE, chuf_pkg::SYM_W'($urandom_range(0, 255)),
                          chuf_pkg::LEN_W'($urandom_range(0, 31)));
            encode_some($urandom_range(2, 6));
        end
    endtask

    initial
    begin : stimulus
        dir_row_t r;
        for (int s = 0; s < chuf_pkg::NUM_SYMBOLS; s++)
        begin
            len_mem[s]  = '0;
            code_mem[s] = '0;
        end
        codes_built = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        for (int i = 0; i < $size(DIR_ROWS); i++)
        begin
            r = DIR_ROWS[i];
            send_item(r.act, r.sym, r.len, r.typed, r.res);
        end
        // back-to-back items against a long output hold-off
        quiet_items = 40;
        hold_go     = 1'b1;
        while (n_items < ITEM_GOAL)
            run_sequence();
        sym_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        $display("Run covered %0d items: %0d builds passed, %0d failed the Kraft check,",
                 n_items, n_build_ok, n_build_bad);
        $display("%0d encodes hit a used symbol; %0d results compared.", n_hits, n_checked);
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver stall: segments of random mode, plus one long hold-off on request
    initial
    begin : stall_pattern
        int mode;
        int seg_left;
        int hold_left;
        mode      = 0;
        seg_left  = 0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(16, 128);
                end
                seg_left--;
                case (mode)
                    0:       res_stall <= 1'b0;
                    1:       res_stall <= ($urandom_range(0, 3) == 0);
                    2:       res_stall <= ($urandom_range(0, 3) != 0);
                    default: res_stall <= (seg_left % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        chuf_pkg::out_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("result with nothing expected: code_word %h code_length %0d status %0d",
                       res_item.code_word, res_item.code_length, res_item.status);
                n_fail++;
            end
            else
            begin
                want = pending_codes.pop_front();
                n_checked++;
                if (res_item.code_word !== want.code_word)
                begin
                    $error("code_word: expected %h, got %h", want.code_word, res_item.code_word);
                    n_fail++;
                end
                if (res_item.code_length !== want.code_length)
                begin
                    $error("code_length: expected %0d, got %0d",
                           want.code_length, res_item.code_length);
                    n_fail++;
                end
                if (res_item.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res_item.status);
                    n_fail++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((sym_valid && !sym_stall) || (res_valid && !res_stall))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_codes.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
hdl/chuf_pkg.sv
hdl/chuf_len_store.sv
hdl/chuf_code_store.sv
hdl/chuf_ctrl.sv
hdl/canonical_huffman_encoder_top.sv
bench/tb_top.sv
